// File: hw/rtl/ordered_record_list_engine_unit_defines.svh
// Assertion helpers for the ordered record list engine
`ifndef ORDERED_RECORD_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_RECORD_LIST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define ORLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ORLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/orle_pkg.sv
package orle_pkg;

  localparam int CAPACITY     = 64;
  localparam int PAYLOAD_BITS = 16;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 7;
  localparam int KEY_W  = 32;
  localparam int PAY_W  = PAYLOAD_BITS;
  localparam int LEN_W  = 7;
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam int WORD_W = KEY_W + PAY_W;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd3;

  typedef enum logic [1:0] {
    PTR_ZERO,
    PTR_CNT_M1,
    PTR_POS_M1,
    PTR_MATCH_P1
  } ptr_sel_e;

  typedef struct packed {
    logic     load;
    ptr_sel_e ptr_sel;
    logic     ptr_load;
    logic     ptr_inc;
    logic     ptr_dec;
    logic     rd_en;
    logic     shift_up;
    logic     shift_dn;
    logic     wr_new;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     cap_match;
    logic     res_load;
    logic     res_ok;
  } orle_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             ins_ok;
    logic             ins_append;
    logic             get_ok;
    logic             empty;
    logic             ptr_at_pos;
    logic             ptr_at_last;
    logic             hit;
    logic             last_cmp;
    logic             out_free;
  } orle_sts_t;

  typedef struct packed {
    logic             is_empty;
    logic [LEN_W-1:0] length;
    logic [PAY_W-1:0] found_payload;
    logic [KEY_W-1:0] found_key;
    logic [POS_W-1:0] found_position;
    logic             ok;
  } orle_res_t;

endpackage

// File: hw/rtl/orle_ctrl.sv
module orle_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  orle_pkg::orle_sts_t sts_i,
  output orle_pkg::orle_cmd_t cmd_o
);
  import orle_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_DECODE    = 4'd1;
  localparam logic [3:0] ST_SEARCH    = 4'd2;
  localparam logic [3:0] ST_INS_SHIFT = 4'd3;
  localparam logic [3:0] ST_INS_DRAIN = 4'd4;
  localparam logic [3:0] ST_INS_PUT   = 4'd5;
  localparam logic [3:0] ST_DEL_SHIFT = 4'd6;
  localparam logic [3:0] ST_DEL_DRAIN = 4'd7;
  localparam logic [3:0] ST_GET_RD    = 4'd8;
  localparam logic [3:0] ST_RESULT    = 4'd9;

  logic [3:0] state_q, state_d;
  logic       ok_q, ok_d;

  always_comb begin
    cmd_o         = '0;
    cmd_o.ptr_sel = PTR_ZERO;
    state_d       = state_q;
    ok_d          = ok_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.op)
          CMD_INSERT: begin
            if (!sts_i.ins_ok) begin
              ok_d    = 1'b0;
              state_d = ST_RESULT;
            end else if (sts_i.ins_append) begin
              state_d = ST_INS_PUT;
            end else begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = PTR_CNT_M1;
              state_d        = ST_INS_SHIFT;
            end
          end
          CMD_DELETE, CMD_FIND: begin
            if (sts_i.empty) begin
              ok_d    = 1'b0;
              state_d = ST_RESULT;
            end else begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = PTR_ZERO;
              state_d        = ST_SEARCH;
            end
          end
          CMD_GET: begin
            if (!sts_i.get_ok) begin
              ok_d    = 1'b0;
              state_d = ST_RESULT;
            end else begin
              cmd_o.ptr_load = 1'b1;
              cmd_o.ptr_sel  = PTR_POS_M1;
              state_d        = ST_GET_RD;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SEARCH: begin
        // reads run one entry ahead of the compare
        cmd_o.rd_en   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        if (sts_i.hit) begin
          cmd_o.cap_match = 1'b1;
          if (sts_i.op == CMD_FIND) begin
            ok_d    = 1'b1;
            state_d = ST_RESULT;
          end else if (sts_i.last_cmp) begin
            state_d = ST_DEL_DRAIN;
          end else begin
            cmd_o.ptr_load = 1'b1;
            cmd_o.ptr_sel  = PTR_MATCH_P1;
            state_d        = ST_DEL_SHIFT;
          end
        end else if (sts_i.last_cmp) begin
          ok_d    = 1'b0;
          state_d = ST_RESULT;
        end
      end
      ST_INS_SHIFT: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.shift_up = 1'b1;
        cmd_o.ptr_dec  = 1'b1;
        if (sts_i.ptr_at_pos) begin
          state_d = ST_INS_DRAIN;
        end
      end
      ST_INS_DRAIN: begin
        state_d = ST_INS_PUT;
      end
      ST_INS_PUT: begin
        cmd_o.wr_new  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        ok_d          = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_DEL_SHIFT: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.shift_dn = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        if (sts_i.ptr_at_last) begin
          state_d = ST_DEL_DRAIN;
        end
      end
      ST_DEL_DRAIN: begin
        cmd_o.cnt_dec = 1'b1;
        ok_d          = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_GET_RD: begin
        cmd_o.rd_en = 1'b1;
        ok_d        = 1'b1;
        state_d     = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.res_ok = ok_q;
  end

  assign s_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
    end
  end

endmodule

// File: hw/rtl/orle_dp.sv
module orle_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [orle_pkg::CMD_W-1:0]    op_i,
  input  logic [orle_pkg::POS_W-1:0]    position_i,
  input  logic signed [orle_pkg::KEY_W-1:0] key_i,
  input  logic [orle_pkg::PAY_W-1:0]    payload_i,
  input  orle_pkg::orle_cmd_t           cmd_i,
  output orle_pkg::orle_sts_t           sts_o,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output orle_pkg::orle_res_t           res_o
);
  import orle_pkg::*;

  logic [WORD_W-1:0] mem [CAPACITY];

  logic [CMD_W-1:0]  op_q;
  logic [POS_W-1:0]  pos_q;
  logic [KEY_W-1:0]  key_q;
  logic [PAY_W-1:0]  pay_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  ptr_q;
  logic [WORD_W-1:0] rd_q;
  logic              rd_v_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              pend_q;
  logic [IDX_W-1:0]  pend_addr_q;
  logic [IDX_W-1:0]  match_idx_q;
  logic              m_valid_q;
  orle_res_t         res_q, res_d;

  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  ptr_d;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign pos_m1 = CNT_W'(pos_q - POS_W'(1));

  // status
  assign sts_o.op          = op_q;
  assign sts_o.ins_ok      = (pos_q != '0)
                             && (CMP_W'(pos_q) <= CMP_W'(cnt_q) + CMP_W'(1))
                             && (CMP_W'(cnt_q) < CMP_W'(CAPACITY));
  assign sts_o.ins_append  = (CMP_W'(pos_q) == CMP_W'(cnt_q) + CMP_W'(1));
  assign sts_o.get_ok      = (pos_q != '0) && (CMP_W'(pos_q) <= CMP_W'(cnt_q));
  assign sts_o.empty       = (cnt_q == '0);
  assign sts_o.ptr_at_pos  = (ptr_q == pos_m1);
  assign sts_o.ptr_at_last = (ptr_q == cnt_m1);
  assign sts_o.hit         = rd_v_q && (rd_q[WORD_W-1:PAY_W] == key_q);
  assign sts_o.last_cmp    = rd_v_q && (CNT_W'(rd_idx_q) == cnt_m1);
  assign sts_o.out_free    = !m_valid_q || m_ready_i;

  // walk pointer
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_load) begin
      unique case (cmd_i.ptr_sel)
        PTR_ZERO:     ptr_d = '0;
        PTR_CNT_M1:   ptr_d = cnt_m1;
        PTR_POS_M1:   ptr_d = pos_m1;
        PTR_MATCH_P1: ptr_d = CNT_W'(rd_idx_q) + CNT_W'(1);
        default:      ptr_d = '0;
      endcase
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + CNT_W'(1);
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - CNT_W'(1);
    end
  end

  // a shifted entry is written in the cycle after its read; new records only when no shift is due
  assign wr_en   = pend_q || cmd_i.wr_new;
  assign wr_addr = pend_q ? pend_addr_q : pos_m1[IDX_W-1:0];
  assign wr_data = pend_q ? rd_q : {key_q, pay_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[ptr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= ptr_q[IDX_W-1:0];
    if (cmd_i.load) begin
      op_q  <= op_i;
      pos_q <= position_i;
      key_q <= key_i;
      pay_q <= payload_i;
    end
    if (cmd_i.cap_match) begin
      match_idx_q <= rd_idx_q;
    end
    if (cmd_i.shift_up) begin
      pend_addr_q <= ptr_q[IDX_W-1:0] + IDX_W'(1);
    end else begin
      pend_addr_q <= ptr_q[IDX_W-1:0] - IDX_W'(1);
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ptr_q     <= '0;
      rd_v_q    <= 1'b0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      rd_v_q <= cmd_i.rd_en;
      pend_q <= cmd_i.rd_en && (cmd_i.shift_up || cmd_i.shift_dn);
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_m1;
      end
      if (cmd_i.res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // result word
  always_comb begin
    res_d                = '0;
    res_d.ok             = cmd_i.res_ok;
    res_d.length         = LEN_W'(cnt_q);
    res_d.is_empty       = (cnt_q == '0);
    if (cmd_i.res_ok && (op_q == CMD_FIND)) begin
      res_d.found_position = POS_W'(match_idx_q) + POS_W'(1);
    end
    if (cmd_i.res_ok && (op_q == CMD_GET)) begin
      res_d.found_key     = rd_q[WORD_W-1:PAY_W];
      res_d.found_payload = rd_q[PAY_W-1:0];
    end
  end

  assign m_valid_o = m_valid_q;
  assign res_o     = res_q;

endmodule

// File: hw/rtl/ordered_record_list_engine_unit.sv
// Ordered record list engine: keeps up to 64 records (signed key, payload) in list order.
// Input channel s_axis: tuser carries the command (insert at position, delete by key,
// find key, get at position); tdata carries position, key and payload.
// Output channel m_axis: one result transfer per input transfer, carrying the ok flag,
// the found position, key and payload, and the list length and empty flag after the op.
// Items are handled one at a time; s_axis_tready is high only while the engine is idle.
// Steps per item: a failed or empty-list op goes straight to the result; get reads the entry
//   at its position; append insert writes at the end; insert at p first shifts the records
//   from p to the end up by one entry; find walks from the head until the key hits or the
//   list ends; delete searches to the entry, then shifts the tail down.
// The walks are set by the record memory: one read and one write port, one entry a cycle.
// The result sits in an output register; the engine returns to idle and takes the next
// item while that result waits, and only stalls an item's completion if the previous
// result has still not been taken by the receiver.
// Reset clears the record count and handshake state; the list is empty afterwards.
// The record memory is not cleared; entries beyond the count may be read but never reach a result.
`include "ordered_record_list_engine_unit_defines.svh"

module ordered_record_list_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // position[6:0], key[38:7], payload[54:39], zero pad
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // ok[0], found_position[7:1], found_key[39:8],
                                     // found_payload[55:40], length[62:56], is_empty[63]
);
  import orle_pkg::*;

  orle_cmd_t cmd;
  orle_sts_t sts;
  orle_res_t res;
  logic      s_take;

  orle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  orle_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (s_axis_tuser),
    .position_i (s_axis_tdata[6:0]),
    .key_i      (s_axis_tdata[38:7]),
    .payload_i  (s_axis_tdata[54:39]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .res_o      (res)
  );

  assign m_axis_tdata = res;
  assign s_take       = s_axis_tvalid && s_axis_tready;

  `ORLE_ASSERT_NXT(a_busy_after_take, s_take, !s_axis_tready, "busy after take")
  `ORLE_ASSERT_IMP(a_len_bound, m_axis_tvalid, res.length <= LEN_W'(CAPACITY), "length bound")
  `ORLE_ASSERT_IMP(a_empty_flag, m_axis_tvalid, res.is_empty == (res.length == '0), "empty flag")

endmodule
